>>> sv/omniwk_pkg.sv
// Shared types, widths and constants for the omni wheel kinematics and PWM block.
package omniwk_pkg;

   // Fixed point of speeds and register values
   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 16;

   // Register file
   localparam int NUM_REGS = 7;
   localparam int IDX_W    = 3;
   localparam logic [IDX_W-1:0] REG_COS_HEADING      = 3'd0;
   localparam logic [IDX_W-1:0] REG_SIN_HEADING      = 3'd1;
   localparam logic [IDX_W-1:0] REG_INV_WHEEL_RADIUS = 3'd2;
   localparam logic [IDX_W-1:0] REG_ARM_LENGTH       = 3'd3;
   localparam logic [IDX_W-1:0] REG_DEADBAND         = 3'd4;
   localparam logic [IDX_W-1:0] REG_PWM_GAIN         = 3'd5;
   localparam logic [IDX_W-1:0] REG_PWM_OFFSET       = 3'd6;

   // Coefficients 1/3 and 1/sqrt(3), scaled by 2^K_SHIFT
   localparam int K_SHIFT = 20;
   localparam int K_W     = K_SHIFT + 1;
   localparam logic signed [K_W-1:0] K_THIRD  = 21'sd349525;
   localparam logic signed [K_W-1:0] K_ISQRT3 = 21'sd605396;

   // Datapath widths
   localparam int PROD_W       = 2 * DATA_W;            // heading products
   localparam int PQ_W         = PROD_W + 1;            // rotated velocity
   localparam int ROT_W        = 2 * DATA_W + 1;        // turn rate times arm
   localparam int KM_W         = PQ_W + K_W;            // coefficient products
   localparam int ROUND_SHIFT  = 34;
   localparam int ROT_SHIFT    = ROUND_SHIFT - FRAC_BITS;
   localparam int T_W          = ROT_W + ROT_SHIFT + 1; // exact bracket sum
   localparam int BRK_W        = T_W - ROUND_SHIFT;     // bracket in Q format
   localparam int SPD_W        = BRK_W + DATA_W + 1;    // wheel speed
   localparam int MAG_W        = SPD_W - 1;             // speed magnitude
   localparam int PRD_W        = MAG_W + DATA_W;        // gain product
   localparam int SUM_W        = PRD_W + 1;             // gain product plus offset
   localparam int OFF_SHIFT    = 2 * FRAC_BITS;
   localparam int PWM_SHIFT    = 3 * FRAC_BITS;

   localparam logic signed [T_W-1:0] ROUND_HALF =
      {{(T_W - ROUND_SHIFT){1'b0}}, 1'b1, {(ROUND_SHIFT - 1){1'b0}}};

   // Pipeline stages
   localparam int NUM_STAGES = 9;
   localparam int ST_PROD    = 0;   // heading and arm products
   localparam int ST_PQ      = 1;   // rotated velocity sums
   localparam int ST_KMUL    = 2;   // coefficient products
   localparam int ST_KSUM    = 3;   // coefficient sum and difference
   localparam int ST_BRK     = 4;   // bracket sum and rounding
   localparam int ST_SPD     = 5;   // wheel speed
   localparam int ST_MAG     = 6;   // magnitude, deadband, direction
   localparam int ST_GAIN    = 7;   // gain product
   localparam int ST_OUT     = 8;   // offset, saturation, output register

   typedef logic signed [BRK_W-1:0] brk_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] cos_heading;
      logic signed [DATA_W-1:0] sin_heading;
      logic [DATA_W-1:0]        inv_wheel_radius;
      logic [DATA_W-1:0]        arm_length;
      logic [DATA_W-1:0]        deadband;
      logic [DATA_W-1:0]        pwm_gain;
      logic [DATA_W-1:0]        pwm_offset;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      cos_heading:      16'hC000,
      sin_heading:      16'h0002,
      inv_wheel_radius: 16'd4876,
      arm_length:       16'd46,
      deadband:         16'd13,
      pwm_gain:         16'd5941,
      pwm_offset:       16'd9272
   };

endpackage

>>> sv/omni_wheel_kinematics_pwm.sv
// Top level: three-wheel omni inverse kinematics with PWM mapping, fully pipelined.
//
// Usage:
//   req_ channel carries one body velocity command (x, y speed and turn rate, Q8.8).
//   rsp_ channel returns per wheel a 16-bit PWM magnitude and a direction bit.
//   csr_ channel writes the seven configuration registers by index; csr_ready is
//   always high and an index of seven is ignored. Write registers only while idle.
// Timing:
//   Nine register stages; the first loads at the accepting edge, and rsp_valid rises
//   once the request has reached the ninth stage, the output register.
//   One request is accepted every cycle while req_stall is low; the multipliers in stages
//   one, three, six and eight each get a stage of their own, so only backpressure limits that rate.
// Reset:
//   Synchronous reset clears every stage valid bit and loads the register defaults.
// Backpressure:
//   Each stage holds its data while the stage after it is full and stalled, so
//   bubbles close up; req_stall rises only when all nine stages hold requests and
//   rsp_stall is high. A stalled response stays on the rsp_ ports unchanged.
module omni_wheel_kinematics_pwm (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [omniwk_pkg::DATA_W-1:0] req_velocity_x,
   input  logic signed [omniwk_pkg::DATA_W-1:0] req_velocity_y,
   input  logic signed [omniwk_pkg::DATA_W-1:0] req_turn_rate,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [omniwk_pkg::DATA_W-1:0]        rsp_pwm_wheel1,
   output logic [omniwk_pkg::DATA_W-1:0]        rsp_pwm_wheel2,
   output logic [omniwk_pkg::DATA_W-1:0]        rsp_pwm_wheel3,
   output logic                                 rsp_dir_wheel1,
   output logic                                 rsp_dir_wheel2,
   output logic                                 rsp_dir_wheel3,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [omniwk_pkg::IDX_W-1:0]         csr_index,
   input  logic [omniwk_pkg::DATA_W-1:0]        csr_data
);

   localparam int NS = omniwk_pkg::NUM_STAGES;

   omniwk_pkg::cfg_type      cfg;
   omniwk_pkg::pipe_ctl_type ctl;
   omniwk_pkg::brk_type      brk1, brk2, brk3;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] ready;
   logic [NS-1:0] upstream;

   // Stage ready chain: a stage loads when empty or when its successor moves on
   always_comb begin
      ready[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   // Valid bits travel with the data
   assign upstream = {valid_ff[NS-2:0], req_valid};

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         valid_in[i] = ready[i] ? upstream[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load  = ready;
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NS-1];

   omniwk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   omniwk_mix u_mix (
      .clock      (clock),
      .ctl        (ctl),
      .cfg        (cfg),
      .velocity_x (req_velocity_x),
      .velocity_y (req_velocity_y),
      .turn_rate  (req_turn_rate),
      .brk_wheel1 (brk1),
      .brk_wheel2 (brk2),
      .brk_wheel3 (brk3)
   );

   omniwk_wheel u_wheel1 (
      .clock (clock),
      .ctl   (ctl),
      .cfg   (cfg),
      .brk   (brk1),
      .pwm   (rsp_pwm_wheel1),
      .dir   (rsp_dir_wheel1)
   );

   omniwk_wheel u_wheel2 (
      .clock (clock),
      .ctl   (ctl),
      .cfg   (cfg),
      .brk   (brk2),
      .pwm   (rsp_pwm_wheel2),
      .dir   (rsp_dir_wheel2)
   );

   omniwk_wheel u_wheel3 (
      .clock (clock),
      .ctl   (ctl),
      .cfg   (cfg),
      .brk   (brk3),
      .pwm   (rsp_pwm_wheel3),
      .dir   (rsp_dir_wheel3)
   );

endmodule

>>> sv/omniwk_csr.sv
// Configuration register file: heading, geometry, deadband and PWM mapping.
module omniwk_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [omniwk_pkg::IDX_W-1:0]      csr_index,
   input  logic [omniwk_pkg::DATA_W-1:0]     csr_data,
   output omniwk_pkg::cfg_type               cfg
);

   omniwk_pkg::cfg_type cfg_ff;
   omniwk_pkg::cfg_type cfg_in;

   // Register write decode; index seven is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            omniwk_pkg::REG_COS_HEADING:      cfg_in.cos_heading      = csr_data;
            omniwk_pkg::REG_SIN_HEADING:      cfg_in.sin_heading      = csr_data;
            omniwk_pkg::REG_INV_WHEEL_RADIUS: cfg_in.inv_wheel_radius = csr_data;
            omniwk_pkg::REG_ARM_LENGTH:       cfg_in.arm_length       = csr_data;
            omniwk_pkg::REG_DEADBAND:         cfg_in.deadband         = csr_data;
            omniwk_pkg::REG_PWM_GAIN:         cfg_in.pwm_gain         = csr_data;
            omniwk_pkg::REG_PWM_OFFSET:       cfg_in.pwm_offset       = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= omniwk_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

>>> sv/omniwk_mix.sv
// Front stages: heading rotation, coefficient products and rounded bracket per wheel.
module omniwk_mix (
   input  logic                                 clock,
   input  omniwk_pkg::pipe_ctl_type             ctl,
   input  omniwk_pkg::cfg_type                  cfg,
   input  logic signed [omniwk_pkg::DATA_W-1:0] velocity_x,
   input  logic signed [omniwk_pkg::DATA_W-1:0] velocity_y,
   input  logic signed [omniwk_pkg::DATA_W-1:0] turn_rate,
   output omniwk_pkg::brk_type                  brk_wheel1,
   output omniwk_pkg::brk_type                  brk_wheel2,
   output omniwk_pkg::brk_type                  brk_wheel3
);

   localparam int PROD_W      = omniwk_pkg::PROD_W;
   localparam int PQ_W        = omniwk_pkg::PQ_W;
   localparam int ROT_W       = omniwk_pkg::ROT_W;
   localparam int KM_W        = omniwk_pkg::KM_W;
   localparam int T_W         = omniwk_pkg::T_W;
   localparam int ROUND_SHIFT = omniwk_pkg::ROUND_SHIFT;

   // stage: heading and arm products
   logic signed [PROD_W-1:0] cvy_ff, svx_ff, cvx_ff, svy_ff;
   logic signed [ROT_W-1:0]  rot1_ff;

   // stage: rotated velocity
   logic signed [PQ_W-1:0]   p_ff, q2_ff;
   logic signed [ROT_W-1:0]  rot2_ff;

   // stage: coefficient products
   logic signed [KM_W-1:0]   third_ff, isq_ff;
   logic signed [PQ_W-1:0]   q3_ff;
   logic signed [ROT_W-1:0]  rot3_ff;

   // stage: coefficient sum and difference, aligned to the exact scale
   logic signed [T_W-1:0]    tq_ff, tplus_ff, tminus_ff, trot_ff;

   // stage: rounded brackets
   omniwk_pkg::brk_type      brk1_ff, brk2_ff, brk3_ff;
   logic signed [T_W-1:0]    sum1, sum2, sum3;

   always_ff @(posedge clock) begin
      if (ctl.load[omniwk_pkg::ST_PROD]) begin
         cvy_ff  <= PROD_W'(cfg.cos_heading) * PROD_W'(velocity_y);
         svx_ff  <= PROD_W'(cfg.sin_heading) * PROD_W'(velocity_x);
         cvx_ff  <= PROD_W'(cfg.cos_heading) * PROD_W'(velocity_x);
         svy_ff  <= PROD_W'(cfg.sin_heading) * PROD_W'(velocity_y);
         rot1_ff <= ROT_W'(turn_rate) * $signed(ROT_W'(cfg.arm_length));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[omniwk_pkg::ST_PQ]) begin
         p_ff    <= PQ_W'(cvy_ff) - PQ_W'(svx_ff);
         q2_ff   <= PQ_W'(cvx_ff) + PQ_W'(svy_ff);
         rot2_ff <= rot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[omniwk_pkg::ST_KMUL]) begin
         third_ff <= KM_W'(p_ff) * KM_W'(omniwk_pkg::K_THIRD);
         isq_ff   <= KM_W'(q2_ff) * KM_W'(omniwk_pkg::K_ISQRT3);
         q3_ff    <= q2_ff;
         rot3_ff  <= rot2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[omniwk_pkg::ST_KSUM]) begin
         tplus_ff  <= T_W'(third_ff) + T_W'(isq_ff);
         tminus_ff <= T_W'(third_ff) - T_W'(isq_ff);
         tq_ff     <= T_W'(q3_ff) <<< omniwk_pkg::K_SHIFT;
         trot_ff   <= (T_W'(rot3_ff) <<< omniwk_pkg::ROT_SHIFT) + omniwk_pkg::ROUND_HALF;
      end
   end

   // Round half up: add half, keep the bits above the fraction (floor)
   assign sum1 = tq_ff + trot_ff;
   assign sum2 = tplus_ff + trot_ff;
   assign sum3 = tminus_ff + trot_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[omniwk_pkg::ST_BRK]) begin
         brk1_ff <= sum1[T_W-1:ROUND_SHIFT];
         brk2_ff <= sum2[T_W-1:ROUND_SHIFT];
         brk3_ff <= sum3[T_W-1:ROUND_SHIFT];
      end
   end

   assign brk_wheel1 = brk1_ff;
   assign brk_wheel2 = brk2_ff;
   assign brk_wheel3 = brk3_ff;

endmodule

>>> sv/omniwk_wheel.sv
// Back stages for one wheel: speed, deadband, gain, offset and PWM saturation.
module omniwk_wheel (
   input  logic                              clock,
   input  omniwk_pkg::pipe_ctl_type          ctl,
   input  omniwk_pkg::cfg_type               cfg,
   input  omniwk_pkg::brk_type               brk,
   output logic [omniwk_pkg::DATA_W-1:0]     pwm,
   output logic                              dir
);

   localparam int DATA_W    = omniwk_pkg::DATA_W;
   localparam int SPD_W     = omniwk_pkg::SPD_W;
   localparam int MAG_W     = omniwk_pkg::MAG_W;
   localparam int PRD_W     = omniwk_pkg::PRD_W;
   localparam int SUM_W     = omniwk_pkg::SUM_W;
   localparam int PWM_SHIFT = omniwk_pkg::PWM_SHIFT;

   logic signed [SPD_W-1:0] spd_ff;
   logic [MAG_W-1:0]        mag_ff;
   logic                    dead_ff, dir1_ff;
   logic [PRD_W-1:0]        prd_ff;
   logic                    dead2_ff, dir2_ff;
   logic [DATA_W-1:0]       pwm_ff;
   logic                    dir_ff;

   logic                    neg;
   logic [MAG_W-1:0]        mag_in;
   logic [MAG_W-1:0]        dead_lim;
   logic [SUM_W-1:0]        pwm_sum;
   logic [SUM_W-PWM_SHIFT-1:0] pwm_quo;
   logic [DATA_W-1:0]       pwm_in;

   // Wheel speed, scaled by 2^(2F)
   always_ff @(posedge clock) begin
      if (ctl.load[omniwk_pkg::ST_SPD]) begin
         spd_ff <= SPD_W'(brk) * $signed(SPD_W'(cfg.inv_wheel_radius));
      end
   end

   // Magnitude and deadband test
   assign neg      = spd_ff[SPD_W-1];
   assign mag_in   = neg ? MAG_W'(-spd_ff) : MAG_W'(spd_ff);
   assign dead_lim = MAG_W'(cfg.deadband) << omniwk_pkg::FRAC_BITS;

   always_ff @(posedge clock) begin
      if (ctl.load[omniwk_pkg::ST_MAG]) begin
         mag_ff  <= mag_in;
         dead_ff <= (mag_in <= dead_lim);
         dir1_ff <= !neg;
      end
   end

   // Gain product
   always_ff @(posedge clock) begin
      if (ctl.load[omniwk_pkg::ST_GAIN]) begin
         prd_ff   <= PRD_W'(mag_ff) * PRD_W'(cfg.pwm_gain);
         dead2_ff <= dead_ff;
         dir2_ff  <= dir1_ff;
      end
   end

   // Offset, truncate, saturate
   assign pwm_sum = SUM_W'(prd_ff) + (SUM_W'(cfg.pwm_offset) << omniwk_pkg::OFF_SHIFT);
   assign pwm_quo = pwm_sum[SUM_W-1:PWM_SHIFT];

   always_comb begin
      if (dead2_ff) begin
         pwm_in = '0;
      end else if (|pwm_quo[SUM_W-PWM_SHIFT-1:DATA_W]) begin
         pwm_in = '1;
      end else begin
         pwm_in = pwm_quo[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[omniwk_pkg::ST_OUT]) begin
         pwm_ff <= pwm_in;
         dir_ff <= dir2_ff;
      end
   end

   assign pwm = pwm_ff;
   assign dir = dir_ff;

endmodule

>>> sv/omniwk_chk.sv
// Port-level checker for the omni wheel block, bound to the top level.
module omniwk_chk (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_stall,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [omniwk_pkg::DATA_W-1:0]        rsp_pwm_wheel1,
   input  logic [omniwk_pkg::DATA_W-1:0]        rsp_pwm_wheel2,
   input  logic [omniwk_pkg::DATA_W-1:0]        rsp_pwm_wheel3,
   input  logic                                 rsp_dir_wheel1,
   input  logic                                 rsp_dir_wheel2,
   input  logic                                 rsp_dir_wheel3
);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Without backpressure at the output, every stage can move, so requests flow
   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   // An empty output stage means the pipeline can take a request
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output stage");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pwm_wheel1)
         && $stable(rsp_pwm_wheel2) && $stable(rsp_pwm_wheel3)
         && $stable(rsp_dir_wheel1) && $stable(rsp_dir_wheel2)
         && $stable(rsp_dir_wheel3))
      else $error("stalled response changed");

endmodule

bind omni_wheel_kinematics_pwm omniwk_chk u_omniwk_chk (.*);
